// ===== rtl/core/ist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the interval set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int DEF_MAX_INTERVALS = 64;
    localparam int DEF_EDGE_BITS     = 40;
    localparam int FIELD_BITS        = 40;
    localparam int COUNT_BITS        = 7;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUBTRACT = 4'd1,
        OP_POINT    = 4'd2,
        OP_CONTAIN  = 4'd3,
        OP_OVERLAP  = 4'd4,
        OP_TOTAL    = 4'd5,
        OP_WIDER    = 4'd6,
        OP_PRUNE    = 4'd7,
        OP_CLEAR    = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_ORDER = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RUN,
        FSM_DONE
    } fsm_t;

    // chain control: pop shifts every cell toward the head, push loads the selected cell in place of the pop
    typedef struct packed {
        logic pop;
        logic push;
    } ist_ctl_t;

    typedef struct packed {
        logic [3:0]            operation;
        logic [FIELD_BITS-1:0] range_low;
        logic [FIELD_BITS-1:0] range_high;
        logic [FIELD_BITS-1:0] min_width;
    } ist_req_t;

    typedef struct packed {
        logic                  hit;
        logic [FIELD_BITS-1:0] measure;
        logic [COUNT_BITS-1:0] entry_count;
        logic [FIELD_BITS-1:0] lowest_edge;
        logic [FIELD_BITS-1:0] highest_edge;
        logic [1:0]            status;
    } ist_res_t;

endpackage

// ===== rtl/core/ist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_cell
// One slot of the interval chain: loads a pushed interval or takes its
// upper neighbor's interval on a pop.
// ----------------------------------------------------------------------------
module ist_cell #(
    parameter int EDGE_BITS = ist_pkg::DEF_EDGE_BITS
) (
    input  logic                 clk,
    input  ist_pkg::ist_ctl_t    ctl,
    input  logic                 sel,
    input  logic [EDGE_BITS-1:0] nb_low,
    input  logic [EDGE_BITS-1:0] nb_high,
    input  logic [EDGE_BITS-1:0] ld_low,
    input  logic [EDGE_BITS-1:0] ld_high,
    output logic [EDGE_BITS-1:0] low,
    output logic [EDGE_BITS-1:0] high
);
    import ist_pkg::*;

    logic [EDGE_BITS-1:0] low_reg;
    logic [EDGE_BITS-1:0] high_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push && sel)
        begin
            low_reg  <= ld_low;
            high_reg <= ld_high;
        end
        else if (ctl.pop)
        begin
            low_reg  <= nb_low;
            high_reg <= nb_high;
        end
    end

    assign low  = low_reg;
    assign high = high_reg;

endmodule

// ===== rtl/core/ist_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer: pops entries off the chain head, applies the operation and
// pushes the surviving or new intervals back at the tail.
// ----------------------------------------------------------------------------
module ist_ctrl #(
    parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS,
    parameter int EDGE_BITS     = ist_pkg::DEF_EDGE_BITS,
    localparam int CW           = $clog2(MAX_INTERVALS + 1),
    localparam int IW           = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ist_pkg::ist_req_t    request,
    output logic                 busy,
    output logic                 done,
    output ist_pkg::ist_res_t    result,
    input  logic [EDGE_BITS-1:0] head_low,
    input  logic [EDGE_BITS-1:0] head_high,
    output ist_pkg::ist_ctl_t    ctl,
    output logic [IW-1:0]        push_idx,
    output logic [EDGE_BITS-1:0] push_low,
    output logic [EDGE_BITS-1:0] push_high
);
    import ist_pkg::*;

    typedef logic [EDGE_BITS-1:0] edge_t;

    fsm_t             state_reg, state_next;
    op_t              op_reg, op_next;
    edge_t            lo_reg, lo_next, hi_reg, hi_next, lim_reg, lim_next;
    logic [CW-1:0]    fill_reg, fill_next, remain_reg, remain_next;
    logic             full_reg, full_next;
    logic             pend_reg, pend_next;
    edge_t            pend_low_reg, pend_low_next, pend_high_reg, pend_high_next;
    logic             merging_reg, merging_next, placed_reg, placed_next;
    edge_t            acc_low_reg, acc_low_next, acc_high_reg, acc_high_next;
    edge_t            sum_reg, sum_next;
    logic             hit_reg, hit_next, found_reg, found_next;
    stat_t            stat_reg, stat_next;
    logic             first_reg, first_next;
    edge_t            lowest_reg, lowest_next, highest_reg, highest_next;

    edge_t            lo_in, hi_in, el, eh, ov_a, ov_b, width;
    op_t              op_in;
    logic             pop, push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        lim_reg       <= lim_next;
        remain_reg    <= remain_next;
        full_reg      <= full_next;
        pend_low_reg  <= pend_low_next;
        pend_high_reg <= pend_high_next;
        merging_reg   <= merging_next;
        placed_reg    <= placed_next;
        acc_low_reg   <= acc_low_next;
        acc_high_reg  <= acc_high_next;
        sum_reg       <= sum_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        stat_reg      <= stat_next;
        first_reg     <= first_next;
        lowest_reg    <= lowest_next;
        highest_reg   <= highest_next;
    end

    assign lo_in = EDGE_BITS'(request.range_low);
    assign hi_in = EDGE_BITS'(request.range_high);
    assign op_in = op_t'(request.operation);
    assign el    = head_low;
    assign eh    = head_high;
    assign width = eh - el;
    assign ov_a  = (el > lo_reg) ? el : lo_reg;
    assign ov_b  = (eh < hi_reg) ? eh : hi_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        lim_next       = lim_reg;
        fill_next      = fill_reg;
        remain_next    = remain_reg;
        full_next      = full_reg;
        pend_next      = pend_reg;
        pend_low_next  = pend_low_reg;
        pend_high_next = pend_high_reg;
        merging_next   = merging_reg;
        placed_next    = placed_reg;
        acc_low_next   = acc_low_reg;
        acc_high_next  = acc_high_reg;
        sum_next       = sum_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        stat_next      = stat_reg;
        first_next     = first_reg;
        lowest_next    = lowest_reg;
        highest_next   = highest_reg;
        pop            = 1'b0;
        push           = 1'b0;
        push_low       = el;
        push_high      = eh;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    op_next      = op_in;
                    lo_next      = lo_in;
                    hi_next      = hi_in;
                    lim_next     = EDGE_BITS'(request.min_width);
                    sum_next     = '0;
                    hit_next     = 1'b0;
                    found_next   = 1'b0;
                    stat_next    = STAT_OK;
                    merging_next = 1'b0;
                    placed_next  = 1'b0;
                    first_next   = 1'b0;
                    remain_next  = fill_reg;
                    full_next    = (fill_reg == CW'(MAX_INTERVALS));
                    state_next   = FSM_DONE;
                    if ((op_in == OP_ADD || op_in == OP_SUBTRACT || op_in == OP_CONTAIN ||
                         op_in == OP_OVERLAP) && lo_in > hi_in)
                        stat_next = STAT_ORDER;
                    else
                    begin
                        case (op_in)
                            OP_CLEAR: fill_next = '0;
                            OP_ADD, OP_SUBTRACT, OP_POINT, OP_CONTAIN, OP_OVERLAP,
                            OP_TOTAL, OP_WIDER, OP_PRUNE: state_next = FSM_RUN;
                            default: ;
                        endcase
                    end
                end
            end

            FSM_RUN:
            begin
                if (pend_reg)
                begin
                    push      = 1'b1;
                    push_low  = pend_low_reg;
                    push_high = pend_high_reg;
                    pend_next = 1'b0;
                end
                else if (remain_reg != '0)
                begin
                    pop         = 1'b1;
                    remain_next = remain_reg - CW'(1);
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (placed_reg)
                                push = 1'b1;
                            else if (merging_reg)
                            begin
                                if (el <= hi_reg)
                                    acc_high_next = (eh > acc_high_reg) ? eh : acc_high_reg;
                                else
                                begin
                                    // merged run ends: emit it, then this entry
                                    push           = 1'b1;
                                    push_low       = acc_low_reg;
                                    push_high      = acc_high_reg;
                                    pend_next      = 1'b1;
                                    pend_low_next  = el;
                                    pend_high_next = eh;
                                    merging_next   = 1'b0;
                                    placed_next    = 1'b1;
                                end
                            end
                            else if (eh < lo_reg)
                                push = 1'b1;
                            else if (el <= hi_reg)
                            begin
                                merging_next  = 1'b1;
                                acc_low_next  = (el < lo_reg) ? el : lo_reg;
                                acc_high_next = (eh > hi_reg) ? eh : hi_reg;
                            end
                            else
                            begin
                                placed_next = 1'b1;
                                push        = 1'b1;
                                if (full_reg)
                                    stat_next = STAT_FULL;
                                else
                                begin
                                    // insert ahead of this entry
                                    push_low       = lo_reg;
                                    push_high      = hi_reg;
                                    pend_next      = 1'b1;
                                    pend_low_next  = el;
                                    pend_high_next = eh;
                                end
                            end
                        end
                        OP_SUBTRACT:
                        begin
                            if (el > hi_reg || eh < lo_reg)
                                push = 1'b1;
                            else if (el < lo_reg && hi_reg < eh && lo_reg == hi_reg)
                                push = 1'b1;
                            else if (el < lo_reg && hi_reg < eh && full_reg)
                            begin
                                push      = 1'b1;
                                stat_next = STAT_FULL;
                            end
                            else if (el < lo_reg)
                            begin
                                push      = 1'b1;
                                push_high = lo_reg;
                                if (hi_reg < eh)
                                begin
                                    pend_next      = 1'b1;
                                    pend_low_next  = hi_reg;
                                    pend_high_next = eh;
                                end
                            end
                            else if (hi_reg < eh)
                            begin
                                push     = 1'b1;
                                push_low = hi_reg;
                            end
                        end
                        OP_POINT:
                        begin
                            push = 1'b1;
                            if (lo_reg >= el && lo_reg <= eh)
                                hit_next = 1'b1;
                        end
                        OP_CONTAIN:
                        begin
                            push = 1'b1;
                            if (!found_reg && lo_reg >= el && lo_reg <= eh)
                            begin
                                found_next = 1'b1;
                                hit_next   = (hi_reg <= eh);
                            end
                        end
                        OP_OVERLAP:
                        begin
                            push = 1'b1;
                            if (ov_b >= ov_a)
                                sum_next = sum_reg + (ov_b - ov_a);
                        end
                        OP_TOTAL:
                        begin
                            push     = 1'b1;
                            sum_next = sum_reg + width;
                        end
                        OP_WIDER:
                        begin
                            push = 1'b1;
                            if (width > lim_reg)
                            begin
                                sum_next = sum_reg + width;
                                hit_next = 1'b1;
                            end
                        end
                        OP_PRUNE:
                            push = (width >= lim_reg);
                        default:
                            push = 1'b1;
                    endcase
                end
                else
                begin
                    state_next = FSM_DONE;
                    if (op_reg == OP_ADD)
                    begin
                        if (merging_reg)
                        begin
                            push      = 1'b1;
                            push_low  = acc_low_reg;
                            push_high = acc_high_reg;
                        end
                        else if (!placed_reg)
                        begin
                            if (full_reg)
                                stat_next = STAT_FULL;
                            else
                            begin
                                push      = 1'b1;
                                push_low  = lo_reg;
                                push_high = hi_reg;
                            end
                        end
                    end
                end
            end

            FSM_DONE:
                state_next = FSM_IDLE;

            default:
                state_next = FSM_IDLE;
        endcase

        if (push)
        begin
            if (!first_reg)
                lowest_next = push_low;
            first_next   = 1'b1;
            highest_next = push_high;
        end
        if (state_reg == FSM_RUN)
            fill_next = fill_reg + CW'(push) - CW'(pop);
    end

    assign ctl.pop  = pop;
    assign ctl.push = push;
    assign push_idx = IW'(fill_reg - CW'(pop));

    assign busy = (state_reg != FSM_IDLE);
    assign done = (state_reg == FSM_DONE);

    assign result.hit          = hit_reg;
    assign result.measure      = FIELD_BITS'(sum_reg);
    assign result.entry_count  = COUNT_BITS'(fill_reg);
    assign result.lowest_edge  = (fill_reg != '0) ? FIELD_BITS'(lowest_reg) : '0;
    assign result.highest_edge = (fill_reg != '0) ? FIELD_BITS'(highest_reg) : '0;
    assign result.status       = stat_reg;

endmodule

// ===== rtl/core/interval_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_table
// Sorted table of disjoint closed intervals with union, subtract, queries,
// width sums and pruning, kept in a chain of interval cells.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload     notes
//  --------  -----------------  ----------  ------------------------------
//  command   start & !busy      request     one beat per operation
//  result    done (1 cycle)     result      one beat per command beat
//
// An operation that walks the table pops each stored entry off the chain
// head through the sequencer and pushes the surviving or new pieces back at
// the tail; a split or insert pushes its second piece as a separate step.
// Clear, reversed edges and unknown codes skip the walk and go straight to
// the result.
// Reset clears the count and the sequencer only; cell contents are not reset.
// The receiver cannot stall: the result beat is shown for exactly one cycle.
//
module interval_set_table #(
    parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS,
    parameter int EDGE_BITS     = ist_pkg::DEF_EDGE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ist_pkg::ist_req_t request,
    output logic              busy,
    output logic              done,
    output ist_pkg::ist_res_t result
);
    import ist_pkg::*;

    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    ist_ctl_t             ctl;
    logic [IW-1:0]        push_idx;
    logic [EDGE_BITS-1:0] push_low, push_high;
    logic [EDGE_BITS-1:0] cell_low  [MAX_INTERVALS];
    logic [EDGE_BITS-1:0] cell_high [MAX_INTERVALS];

    ist_ctrl #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .EDGE_BITS    (EDGE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .head_low (cell_low[0]),
        .head_high(cell_high[0]),
        .ctl      (ctl),
        .push_idx (push_idx),
        .push_low (push_low),
        .push_high(push_high)
    );

    // cell 0 is the head; pops move every entry one cell toward it
    for (genvar i = 0; i < MAX_INTERVALS; i++)
    begin : g_cell
        logic [EDGE_BITS-1:0] nb_low, nb_high;
        if (i == MAX_INTERVALS - 1)
        begin : g_last
            assign nb_low  = '0;
            assign nb_high = '0;
        end
        else
        begin : g_mid
            assign nb_low  = cell_low[i+1];
            assign nb_high = cell_high[i+1];
        end

        ist_cell #(
            .EDGE_BITS(EDGE_BITS)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .sel    (push_idx == IW'(i)),
            .nb_low (nb_low),
            .nb_high(nb_high),
            .ld_low (push_low),
            .ld_high(push_high),
            .low    (cell_low[i]),
            .high   (cell_high[i])
        );
    end

endmodule

// ===== rtl/core/ist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks for the interval set table, bound to the top level.
// ----------------------------------------------------------------------------
module ist_checker #(
    parameter int MAX_INTERVALS = ist_pkg::DEF_MAX_INTERVALS
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ist_pkg::ist_req_t request,
    input ist_pkg::ist_res_t result
);
    import ist_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count <= COUNT_BITS'(MAX_INTERVALS)))
        else $error("entry count above capacity");

    a_empty_edges: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.entry_count == '0) |->
            (result.lowest_edge == '0 && result.highest_edge == '0))
        else $error("empty table reports edges");

    a_order_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STAT_ORDER) |-> (!result.hit && result.measure == '0))
        else $error("reversed edges gave a measure or hit");

endmodule

bind interval_set_table ist_checker #(.MAX_INTERVALS(MAX_INTERVALS)) u_ist_checker (.*);
